// ===== design/pcft_pkg.sv =====
// Shared constants, types and helpers for the priority class FIFO table.
`timescale 1ns / 1ps
package pcft_pkg;

	localparam int NUM_CLASSES = 8;
	localparam int CLASS_DEPTH = 16;

	localparam int DATA_W  = 32;
	localparam int COUNT_W = 8;

	localparam int SLOT_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam int ALLOC_W = $clog2(NUM_CLASSES + 1);
	localparam int PTR_W   = $clog2(CLASS_DEPTH);
	localparam int FILL_W  = $clog2(CLASS_DEPTH + 1);
	localparam int TOTAL_W = $clog2(NUM_CLASSES * CLASS_DEPTH + 1);

	// Store address is {slot, pointer}; each slot owns a power-of-two window.
	localparam int ADDR_W      = SLOT_W + PTR_W;
	localparam int STORE_DEPTH = 1 << ADDR_W;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] hit_slot;
		logic              has_free;
		logic [SLOT_W-1:0] free_slot;
	} dir_lookup_t;

	typedef struct packed {
		logic              push;
		logic              pop;
		logic [SLOT_W-1:0] slot;
	} ptr_update_t;

	function automatic logic [COUNT_W-1:0] sat_count(input logic [TOTAL_W-1:0] c);
		logic [31:0] wide;
		wide = 32'(c);
		if (wide > 32'd255) begin
			return {COUNT_W{1'b1}};
		end
		return COUNT_W'(wide);
	endfunction

endpackage

// ===== design/pcft_cmd_if.sv =====
// Command channel: operation, value and priority tag.
`timescale 1ns / 1ps
interface pcft_cmd_if;
	logic                                valid;
	logic                                ready;
	logic                                op;
	logic signed [pcft_pkg::DATA_W-1:0]  item_value;
	logic signed [pcft_pkg::DATA_W-1:0]  priority_tag;

	modport source (output valid, op, item_value, priority_tag, input ready);
	modport sink   (input valid, op, item_value, priority_tag, output ready);
endinterface

// ===== design/pcft_rsp_if.sv =====
// Response channel: status, popped value and total count.
`timescale 1ns / 1ps
interface pcft_rsp_if;
	logic                                valid;
	logic                                ready;
	logic                                ok;
	logic signed [pcft_pkg::DATA_W-1:0]  popped_value;
	logic [pcft_pkg::COUNT_W-1:0]        total_count;

	modport source (output valid, ok, popped_value, total_count, input ready);
	modport sink   (input valid, ok, popped_value, total_count, output ready);
endinterface

// ===== design/pcft_ram.sv =====
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module pcft_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                          wdata,
	output logic [WIDTH-1:0]                          rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;
endmodule

// ===== design/pcft_class_dir.sv =====
// Class directory: tag per slot, parallel tag match, in-order slot allocation.
`timescale 1ns / 1ps
module pcft_class_dir (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [pcft_pkg::DATA_W-1:0]        tag,
	input  logic                               claim,
	output pcft_pkg::dir_lookup_t              lookup
);
	logic [pcft_pkg::DATA_W-1:0]  tag_q [pcft_pkg::NUM_CLASSES];
	// Slots are taken lowest first and never freed, so a count says which are in use.
	logic [pcft_pkg::ALLOC_W-1:0] alloc_q;
	logic [pcft_pkg::NUM_CLASSES-1:0] match;
	logic [pcft_pkg::SLOT_W-1:0]  hit_slot;

	always_comb begin
		hit_slot = '0;
		for (int i = 0; i < pcft_pkg::NUM_CLASSES; i++) begin
			match[i] = (pcft_pkg::ALLOC_W'(i) < alloc_q) && (tag_q[i] == tag);
			if (match[i]) begin
				hit_slot = hit_slot | pcft_pkg::SLOT_W'(i);
			end
		end
	end

	assign lookup.hit       = |match;
	assign lookup.hit_slot  = hit_slot;
	assign lookup.has_free  = alloc_q < pcft_pkg::ALLOC_W'(pcft_pkg::NUM_CLASSES);
	assign lookup.free_slot = alloc_q[pcft_pkg::SLOT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alloc_q <= '0;
		end else if (claim) begin
			alloc_q <= alloc_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (claim) begin
			tag_q[alloc_q[pcft_pkg::SLOT_W-1:0]] <= tag;
		end
	end
endmodule

// ===== design/pcft_ptr_file.sv =====
// Per-class read pointer, write pointer and fill level.
`timescale 1ns / 1ps
module pcft_ptr_file (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pcft_pkg::ptr_update_t         upd,
	output logic [pcft_pkg::PTR_W-1:0]    rd_ptr,
	output logic [pcft_pkg::PTR_W-1:0]    wr_ptr,
	output logic [pcft_pkg::FILL_W-1:0]   fill
);
	logic [pcft_pkg::PTR_W-1:0]  rp_q   [pcft_pkg::NUM_CLASSES];
	logic [pcft_pkg::PTR_W-1:0]  wp_q   [pcft_pkg::NUM_CLASSES];
	logic [pcft_pkg::FILL_W-1:0] fill_q [pcft_pkg::NUM_CLASSES];

	function automatic logic [pcft_pkg::PTR_W-1:0] advance(input logic [pcft_pkg::PTR_W-1:0] p);
		if (p == pcft_pkg::PTR_W'(pcft_pkg::CLASS_DEPTH - 1)) begin
			return '0;
		end
		return p + 1'b1;
	endfunction

	assign rd_ptr = rp_q[upd.slot];
	assign wr_ptr = wp_q[upd.slot];
	assign fill   = fill_q[upd.slot];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < pcft_pkg::NUM_CLASSES; i++) begin
				rp_q[i]   <= '0;
				wp_q[i]   <= '0;
				fill_q[i] <= '0;
			end
		end else if (upd.push) begin
			wp_q[upd.slot]   <= advance(wp_q[upd.slot]);
			fill_q[upd.slot] <= fill_q[upd.slot] + 1'b1;
		end else if (upd.pop) begin
			rp_q[upd.slot]   <= advance(rp_q[upd.slot]);
			fill_q[upd.slot] <= fill_q[upd.slot] - 1'b1;
		end
	end
endmodule

// ===== design/priority_class_fifo_table.sv =====
// Top level of the priority class FIFO table.
`timescale 1ns / 1ps
// Usage
//  cmd (sink): one beat per operation. op = insert puts item_value at the tail of
//    the queue of priority_tag; op = remove takes the head of that queue. A tag gets
//    the lowest free class slot on its first insert and keeps it forever.
//  rsp (source): one beat per command, in command order: ok, the popped value
//    (zero unless a remove succeeded) and the number of values held afterwards.
//  Order: an insert goes from the lookup state to the output register; a remove
//    goes through lookup and read (the read is the registered read of the value store).
//  One command at a time; cmd.ready is high only while no command is in work,
//    so a new command is taken only once the last one has left lookup (and read).
//    The tag match over all slots is done in lookup; the store read is done in read.
//  The response sits in an output register, so the next command is taken while a
//    result waits. If rsp.ready stays low, a following insert waits in its lookup
//    cycle without touching any state; a following remove does its pop and store
//    read, then waits in the read cycle with the value held, until the register
//    frees up.
//  Reset: slots, pointers, fill levels and the total count clear at once; the
//    value store and the slot tags are not cleared and need no clearing pass.
module priority_class_fifo_table (
	input logic        clk,
	input logic        arst_n,
	pcft_cmd_if.sink   cmd,
	pcft_rsp_if.source rsp
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LOOK = 2'd1;
	localparam logic [1:0] ST_READ = 2'd2;

	logic [1:0]                    state_q, state_d;
	logic                          op_q;
	logic [pcft_pkg::DATA_W-1:0]   val_q;
	logic [pcft_pkg::DATA_W-1:0]   tag_q;
	logic                          rem_ok_q;
	logic [pcft_pkg::TOTAL_W-1:0]  total_q, total_d;

	logic                          rsp_valid_q;
	logic                          rsp_ok_q;
	logic [pcft_pkg::DATA_W-1:0]   rsp_pop_q;
	logic [pcft_pkg::COUNT_W-1:0]  rsp_total_q;

	pcft_pkg::dir_lookup_t         lookup;
	pcft_pkg::ptr_update_t         upd;
	logic [pcft_pkg::PTR_W-1:0]    rd_ptr, wr_ptr;
	logic [pcft_pkg::FILL_W-1:0]   fill;
	logic                          claim;

	logic                          cmd_beat;
	logic                          out_free;
	logic                          ins_ok, rem_ok;
	logic                          go_ins, go_rem;
	logic [pcft_pkg::SLOT_W-1:0]   slot;
	logic                          ram_we, ram_re;
	logic [pcft_pkg::ADDR_W-1:0]   ram_addr;
	logic [pcft_pkg::DATA_W-1:0]   ram_rdata;

	assign cmd.ready = (state_q == ST_IDLE);
	assign cmd_beat  = cmd.valid && cmd.ready;
	// Output register can take a result this cycle.
	assign out_free  = !rsp_valid_q || rsp.ready;

	// A known tag uses its slot; a new tag would take the next free one.
	assign slot   = lookup.hit ? lookup.hit_slot : lookup.free_slot;
	assign ins_ok = (lookup.hit || lookup.has_free) &&
	                (fill < pcft_pkg::FILL_W'(pcft_pkg::CLASS_DEPTH));
	assign rem_ok = lookup.hit && (fill != '0);

	// Inserts finish in the lookup cycle and need room for the result;
	// removes move on to the store read regardless.
	assign go_ins = (state_q == ST_LOOK) && (op_q == pcft_pkg::OP_INSERT) && out_free;
	assign go_rem = (state_q == ST_LOOK) && (op_q == pcft_pkg::OP_REMOVE);

	assign claim    = go_ins && ins_ok && !lookup.hit;
	assign upd.push = go_ins && ins_ok;
	assign upd.pop  = go_rem && rem_ok;
	assign upd.slot = slot;

	assign ram_we   = upd.push;
	assign ram_re   = upd.pop;
	assign ram_addr = {slot, (op_q == pcft_pkg::OP_INSERT) ? wr_ptr : rd_ptr};

	always_comb begin
		total_d = total_q;
		if (upd.push) begin
			total_d = total_q + 1'b1;
		end else if (upd.pop) begin
			total_d = total_q - 1'b1;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_beat) begin
					state_d = ST_LOOK;
				end
			end
			ST_LOOK: begin
				if (go_rem) begin
					state_d = ST_READ;
				end else if (go_ins) begin
					state_d = ST_IDLE;
				end
			end
			ST_READ: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	pcft_class_dir u_dir (
		.clk    (clk),
		.arst_n (arst_n),
		.tag    (tag_q),
		.claim  (claim),
		.lookup (lookup)
	);

	pcft_ptr_file u_ptr (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (upd),
		.rd_ptr (rd_ptr),
		.wr_ptr (wr_ptr),
		.fill   (fill)
	);

	pcft_ram #(
		.WIDTH (pcft_pkg::DATA_W),
		.DEPTH (pcft_pkg::STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (val_q),
		.rdata (ram_rdata)
	);

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			total_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			total_q <= total_d;
			if (go_ins || ((state_q == ST_READ) && out_free)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Command capture and result payload.
	always_ff @(posedge clk) begin
		if (cmd_beat) begin
			op_q  <= cmd.op;
			val_q <= cmd.item_value;
			tag_q <= cmd.priority_tag;
		end
		if (go_rem) begin
			rem_ok_q <= rem_ok;
		end
		if (go_ins) begin
			rsp_ok_q    <= ins_ok;
			rsp_pop_q   <= '0;
			rsp_total_q <= pcft_pkg::sat_count(total_d);
		end else if ((state_q == ST_READ) && out_free) begin
			rsp_ok_q    <= rem_ok_q;
			rsp_pop_q   <= rem_ok_q ? ram_rdata : '0;
			rsp_total_q <= pcft_pkg::sat_count(total_q);
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.ok           = rsp_ok_q;
	assign rsp.popped_value = rsp_pop_q;
	assign rsp.total_count  = rsp_total_q;
endmodule

// ===== design/pcft_checker.sv =====
// Port-level checks for the priority class FIFO table, bound to the top level.
`timescale 1ns / 1ps
module pcft_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               cmd_valid,
	input logic                               cmd_ready,
	input logic                               rsp_valid,
	input logic                               rsp_ready,
	input logic                               rsp_ok,
	input logic [pcft_pkg::DATA_W-1:0]        rsp_popped_value,
	input logic [pcft_pkg::COUNT_W-1:0]       rsp_total_count
);
	logic cmd_beat;
	assign cmd_beat = cmd_valid && cmd_ready;

	// One command in work at a time.
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_beat |=> !cmd_ready)
		else $error("command taken while another was in work");

	// A fresh result rises only after a matching insert or remove command beat.
	a_rsp_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> ($past(cmd_beat, 2) || $past(cmd_beat, 3)))
		else $error("result without a matching command beat");

	// A failed operation never reports a popped value.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ok) |-> (rsp_popped_value == '0))
		else $error("failed operation with nonzero popped value");

	// A stalled result holds.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=>
		(rsp_valid && $stable(rsp_ok) && $stable(rsp_popped_value) &&
		 $stable(rsp_total_count)))
		else $error("stalled result changed");
endmodule

bind priority_class_fifo_table pcft_checker u_pcft_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.cmd_valid        (cmd.valid),
	.cmd_ready        (cmd.ready),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_ok           (rsp.ok),
	.rsp_popped_value (rsp.popped_value),
	.rsp_total_count  (rsp.total_count)
);
